@@ rtl/oack_pkg.sv @@
// package: phase codes, option name tables and limits for the oack option parser
package oack_pkg;

  localparam logic [15:0] DEFAULT_BLOCK = 16'd512;
  localparam logic [15:0] DEFAULT_WINDOW = 16'd1;
  localparam logic [15:0] MAX_BLOCK = 16'd65464;
  localparam logic [15:0] MIN_BLOCK = 16'd8;
  localparam logic [7:0] OPCODE_OACK = 8'd6;
  localparam int ACC_W = 17;
  localparam logic [ACC_W-1:0] ACC_LIMIT = '1;
  localparam logic [3:0] BLK_LEN = 4'd7;
  localparam logic [3:0] WIN_LEN = 4'd10;
  localparam logic [3:0] POS_MAX = 4'd15;

  localparam logic CFG_REQ_BLOCK = 1'b0;
  localparam logic CFG_REQ_WINDOW = 1'b1;

  typedef enum logic [2:0] {
    PH_OP0,
    PH_OP1,
    PH_NAME,
    PH_VLEAD,
    PH_VDIG,
    PH_SKIP
  } phase_t;

  function automatic logic [7:0] blk_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0: c = "b";
      4'd1: c = "l";
      4'd2: c = "k";
      4'd3: c = "s";
      4'd4: c = "i";
      4'd5: c = "z";
      4'd6: c = "e";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] win_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0: c = "w";
      4'd1: c = "i";
      4'd2: c = "n";
      4'd3: c = "d";
      4'd4: c = "o";
      4'd5: c = "w";
      4'd6: c = "s";
      4'd7: c = "i";
      4'd8: c = "z";
      4'd9: c = "e";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/oack_option_parser.sv @@
// top level: tftp option-acknowledgment parser, one packet byte per cycle while in_stall is low
//
// The input channel carries one packet byte per beat (opcode bytes first),
// with in_last_byte set on the final byte. Each beat lands in an input
// register and is parsed from there by a short update of the parse
// state. On the last byte a verdict beat goes to the output register:
// out_accepted, and the agreed block and window sizes (512 and 1 when the
// packet is rejected or the option is absent).
// The verdict is registered: the last byte passes the input register, then the output register.
// Throughput: one byte per cycle, limited by the single parse update and by in_stall.
// The cfg port writes the requested block size (index 0) and the requested
// window size (index 1); write them while no packet is in flight.
// When out_stall holds a verdict, non-last bytes keep flowing; a following
// last byte waits in the input register and in_stall rises until the held
// verdict is taken.
// Reset (synchronous, rst_n low) empties both registers, returns the parse
// state to the first opcode byte and sets the requests to 512 and 0.
module oack_option_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [15:0] out_agreed_block_size,
  output logic [15:0] out_agreed_window_size,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import oack_pkg::*;

  // configuration
  logic [15:0] req_blk_r;
  logic [15:0] req_win_r;

  // input register
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // parse state
  phase_t           phase_r, phase_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic             cand_blk_r, cand_blk_nxt;
  logic             cand_win_r, cand_win_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             digit_r, digit_nxt;
  logic             neg_r, neg_nxt;
  logic             found_r, found_nxt;
  logic             blk_seen_r, blk_seen_nxt;
  logic             win_seen_r, win_seen_nxt;
  logic             fail_r, fail_nxt;
  logic [15:0]      held_blk_r, held_blk_nxt;
  logic [15:0]      held_win_r, held_win_nxt;

  // output register
  logic        out_valid_r;
  logic        acc_ok_r;
  logic [15:0] out_blk_r;
  logic [15:0] out_win_r;

  logic        consume;
  logic        verdict_ok;
  logic [7:0]  lc;
  logic        is_digit;
  logic        is_space;
  logic [20:0] acc_mul;

  assign consume  = in_valid_r && (!last_r || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !consume;

  assign lc       = (byte_r >= "A" && byte_r <= "Z") ? byte_r + 8'd32 : byte_r;
  assign is_digit = (byte_r >= "0") && (byte_r <= "9");
  assign is_space = (byte_r == " ") || (byte_r >= 8'd9 && byte_r <= 8'd13);
  // acc * 10 + digit as two shifts and two adds
  assign acc_mul  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {17'd0, byte_r[3:0]};

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    cand_blk_nxt = cand_blk_r;
    cand_win_nxt = cand_win_r;
    acc_nxt      = acc_r;
    digit_nxt    = digit_r;
    neg_nxt      = neg_r;
    found_nxt    = found_r;
    blk_seen_nxt = blk_seen_r;
    win_seen_nxt = win_seen_r;
    fail_nxt     = fail_r;
    held_blk_nxt = held_blk_r;
    held_win_nxt = held_win_r;

    case (phase_r)
      PH_OP0: begin
        if (byte_r != 8'd0) begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_SKIP;
        end else begin
          phase_nxt = PH_OP1;
        end
      end
      PH_OP1: begin
        if (byte_r != OPCODE_OACK) begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_SKIP;
        end else begin
          phase_nxt    = PH_NAME;
          pos_nxt      = '0;
          cand_blk_nxt = 1'b1;
          cand_win_nxt = 1'b1;
        end
      end
      PH_NAME: begin
        if (byte_r == 8'd0) begin
          // name terminator: pick the option or reject
          if (pos_r != '0 && cand_blk_r && pos_r == BLK_LEN) begin
            cand_blk_nxt = 1'b1;
            cand_win_nxt = 1'b0;
            acc_nxt      = '0;
            digit_nxt    = 1'b0;
            neg_nxt      = 1'b0;
            phase_nxt    = PH_VLEAD;
          end else if (pos_r != '0 && cand_win_r && pos_r == WIN_LEN) begin
            cand_blk_nxt = 1'b0;
            cand_win_nxt = 1'b1;
            acc_nxt      = '0;
            digit_nxt    = 1'b0;
            neg_nxt      = 1'b0;
            phase_nxt    = PH_VLEAD;
          end else begin
            fail_nxt  = 1'b1;
            phase_nxt = PH_SKIP;
          end
        end else begin
          if (pos_r >= BLK_LEN || lc != blk_char(pos_r)) cand_blk_nxt = 1'b0;
          if (pos_r >= WIN_LEN || lc != win_char(pos_r)) cand_win_nxt = 1'b0;
          if (pos_r < POS_MAX) pos_nxt = pos_r + 4'd1;
        end
      end
      PH_VLEAD: begin
        if (byte_r == 8'd0) begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_SKIP;
        end else if (is_space) begin
          phase_nxt = PH_VLEAD;
        end else if (byte_r == "+") begin
          phase_nxt = PH_VDIG;
        end else if (byte_r == "-") begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_VDIG;
        end else if (is_digit) begin
          acc_nxt   = (acc_mul > {4'd0, ACC_LIMIT}) ? ACC_LIMIT : acc_mul[ACC_W-1:0];
          digit_nxt = 1'b1;
          phase_nxt = PH_VDIG;
        end else begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_SKIP;
        end
      end
      PH_VDIG: begin
        if (byte_r == 8'd0) begin
          // value terminator: digit, sign, range and duplicate checks
          if (!digit_r || neg_r) begin
            fail_nxt  = 1'b1;
            phase_nxt = PH_SKIP;
          end else if (cand_blk_r && !cand_win_r) begin
            if (blk_seen_r || req_blk_r == DEFAULT_BLOCK ||
                acc_r < {1'b0, MIN_BLOCK} || acc_r > {1'b0, req_blk_r} ||
                acc_r > {1'b0, MAX_BLOCK}) begin
              fail_nxt  = 1'b1;
              phase_nxt = PH_SKIP;
            end else begin
              held_blk_nxt = acc_r[15:0];
              blk_seen_nxt = 1'b1;
              found_nxt    = 1'b1;
              phase_nxt    = PH_NAME;
              pos_nxt      = '0;
              cand_blk_nxt = 1'b1;
              cand_win_nxt = 1'b1;
            end
          end else begin
            if (win_seen_r || req_win_r == 16'd0 ||
                acc_r < {1'b0, DEFAULT_WINDOW} || acc_r > {1'b0, req_win_r}) begin
              fail_nxt  = 1'b1;
              phase_nxt = PH_SKIP;
            end else begin
              held_win_nxt = acc_r[15:0];
              win_seen_nxt = 1'b1;
              found_nxt    = 1'b1;
              phase_nxt    = PH_NAME;
              pos_nxt      = '0;
              cand_blk_nxt = 1'b1;
              cand_win_nxt = 1'b1;
            end
          end
        end else if (is_digit) begin
          acc_nxt   = (acc_mul > {4'd0, ACC_LIMIT}) ? ACC_LIMIT : acc_mul[ACC_W-1:0];
          digit_nxt = 1'b1;
        end else begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_SKIP;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  assign verdict_ok = !fail_nxt && phase_nxt == PH_NAME && pos_nxt == '0 && found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_blk_r <= DEFAULT_BLOCK;
      req_win_r <= 16'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_REQ_BLOCK:  req_blk_r <= cfg_wdata;
        CFG_REQ_WINDOW: req_win_r <= cfg_wdata;
        default:        req_blk_r <= req_blk_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_packet_byte;
      last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (consume && last_r)) begin
      phase_r    <= PH_OP0;
      pos_r      <= '0;
      cand_blk_r <= 1'b1;
      cand_win_r <= 1'b1;
      acc_r      <= '0;
      digit_r    <= 1'b0;
      neg_r      <= 1'b0;
      found_r    <= 1'b0;
      blk_seen_r <= 1'b0;
      win_seen_r <= 1'b0;
      fail_r     <= 1'b0;
      held_blk_r <= DEFAULT_BLOCK;
      held_win_r <= DEFAULT_WINDOW;
    end else if (consume) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      cand_blk_r <= cand_blk_nxt;
      cand_win_r <= cand_win_nxt;
      acc_r      <= acc_nxt;
      digit_r    <= digit_nxt;
      neg_r      <= neg_nxt;
      found_r    <= found_nxt;
      blk_seen_r <= blk_seen_nxt;
      win_seen_r <= win_seen_nxt;
      fail_r     <= fail_nxt;
      held_blk_r <= held_blk_nxt;
      held_win_r <= held_win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (consume && last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && last_r) begin
      acc_ok_r  <= verdict_ok;
      out_blk_r <= verdict_ok ? held_blk_nxt : DEFAULT_BLOCK;
      out_win_r <= verdict_ok ? held_win_nxt : DEFAULT_WINDOW;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_accepted           = acc_ok_r;
  assign out_agreed_block_size  = out_blk_r;
  assign out_agreed_window_size = out_win_r;

`ifndef NO_ASSERTIONS
  a_reject_defaults: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !acc_ok_r |-> out_blk_r == DEFAULT_BLOCK && out_win_r == DEFAULT_WINDOW)
    else $error("rejected verdict carries non-default sizes");

  a_block_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && acc_ok_r |-> out_blk_r >= MIN_BLOCK && out_blk_r <= MAX_BLOCK &&
      out_win_r != 16'd0)
    else $error("accepted verdict out of range");

  a_packet_restart: assert property (@(posedge clk) disable iff (!rst_n)
    consume && last_r |=> phase_r == PH_OP0 && !fail_r && !found_r)
    else $error("parse state not cleared after last byte");

  a_fail_skips: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r |-> phase_r == PH_SKIP)
    else $error("fault latched outside skip phase");
`endif

endmodule

@@ sim/testbench.sv @@
// testbench for the oack option parser: packet stimulus, verdict prediction and checking
`timescale 1ns / 1ps

import oack_pkg::*;

localparam logic [55:0] BLK_WORD = "blksize";
localparam logic [79:0] WIN_WORD = "windowsize";

typedef struct {
  logic        accepted;
  logic [15:0] block_size;
  logic [15:0] window_size;
} verdict_t;

// byte-level predictor of the parse state plus the queue of verdicts still owed
class verdict_book;
  logic [15:0] req_block;
  logic [15:0] req_window;
  phase_t      stage;
  logic [3:0]  name_len;
  bit          maybe_blk;
  bit          maybe_win;
  logic [16:0] value_acc;
  bit          has_digit;
  bit          minus;
  bit          any_option;
  bit          got_blk;
  bit          got_win;
  bit          failed;
  logic [15:0] held_block;
  logic [15:0] held_window;
  verdict_t    due_verdicts[$];
  int          errors;

  function new();
    req_block = DEFAULT_BLOCK;
    req_window = '0;
    errors = 0;
    clear_packet();
  endfunction

  function void clear_packet();
    stage = PH_OP0;
    name_len = '0;
    maybe_blk = 1'b1;
    maybe_win = 1'b1;
    value_acc = '0;
    has_digit = 1'b0;
    minus = 1'b0;
    any_option = 1'b0;
    got_blk = 1'b0;
    got_win = 1'b0;
    failed = 1'b0;
    held_block = DEFAULT_BLOCK;
    held_window = DEFAULT_WINDOW;
  endfunction

  function void abandon();
    failed = 1'b1;
    stage = PH_SKIP;
  endfunction

  function void open_name();
    stage = PH_NAME;
    name_len = '0;
    maybe_blk = 1'b1;
    maybe_win = 1'b1;
  endfunction

  function void take_digit(logic [7:0] b);
    int unsigned t;
    t = value_acc * 10 + (b - "0");
    value_acc = (t > ACC_LIMIT) ? ACC_LIMIT : t[16:0];
    has_digit = 1'b1;
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    logic [7:0] lc;
    bit ok;
    verdict_t v;
    case (stage)
      PH_OP0: begin
        if (b != 8'd0) abandon();
        else stage = PH_OP1;
      end
      PH_OP1: begin
        if (b != OPCODE_OACK) abandon();
        else open_name();
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          if (name_len == 0) begin
            abandon();
          end else if (maybe_blk && name_len == BLK_LEN) begin
            maybe_win = 1'b0;
            value_acc = '0;
            has_digit = 1'b0;
            minus = 1'b0;
            stage = PH_VLEAD;
          end else if (maybe_win && name_len == WIN_LEN) begin
            maybe_blk = 1'b0;
            value_acc = '0;
            has_digit = 1'b0;
            minus = 1'b0;
            stage = PH_VLEAD;
          end else begin
            abandon();
          end
        end else begin
          lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          if (name_len >= BLK_LEN) maybe_blk = 1'b0;
          else if (lc != BLK_WORD[8*(6-name_len) +: 8]) maybe_blk = 1'b0;
          if (name_len >= WIN_LEN) maybe_win = 1'b0;
          else if (lc != WIN_WORD[8*(9-name_len) +: 8]) maybe_win = 1'b0;
          if (name_len != POS_MAX) name_len++;
        end
      end
      PH_VLEAD: begin
        if (b == 8'd0) begin
          abandon();
        end else if (b == "+") begin
          stage = PH_VDIG;
        end else if (b == "-") begin
          minus = 1'b1;
          stage = PH_VDIG;
        end else if (b >= "0" && b <= "9") begin
          take_digit(b);
          stage = PH_VDIG;
        end else if (!(b == " " || (b >= 8'd9 && b <= 8'd13))) begin
          abandon();
        end
      end
      PH_VDIG: begin
        if (b == 8'd0) begin
          if (!has_digit || minus) begin
            abandon();
          end else if (maybe_blk) begin
            if (got_blk || req_block == DEFAULT_BLOCK || value_acc < MIN_BLOCK ||
                value_acc > req_block || value_acc > MAX_BLOCK) begin
              abandon();
            end else begin
              held_block = value_acc[15:0];
              got_blk = 1'b1;
              any_option = 1'b1;
              open_name();
            end
          end else begin
            if (got_win || req_window == 0 || value_acc == 0 || value_acc > req_window) begin
              abandon();
            end else begin
              held_window = value_acc[15:0];
              got_win = 1'b1;
              any_option = 1'b1;
              open_name();
            end
          end
        end else if (b >= "0" && b <= "9") begin
          take_digit(b);
        end else begin
          abandon();
        end
      end
      default: begin
      end
    endcase

    if (last) begin
      ok = !failed && stage == PH_NAME && name_len == 0 && any_option;
      v.accepted = ok;
      v.block_size = ok ? held_block : DEFAULT_BLOCK;
      v.window_size = ok ? held_window : DEFAULT_WINDOW;
      due_verdicts.push_back(v);
      clear_packet();
    end
  endfunction

  task report(string what);
    $display("verdict error at %0t: %s", $realtime, what);
    errors++;
  endtask

  task check_verdict(logic acc, logic [15:0] blk, logic [15:0] win);
    verdict_t v;
    if (due_verdicts.size() == 0) begin
      report("verdict beat with none outstanding");
      return;
    end
    v = due_verdicts.pop_front();
    if (acc !== v.accepted)
      report($sformatf("accepted %b, want %b", acc, v.accepted));
    if (blk !== v.block_size)
      report($sformatf("block size %0d, want %0d", blk, v.block_size));
    if (win !== v.window_size)
      report($sformatf("window size %0d, want %0d", win, v.window_size));
  endtask
endclass

module testbench;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_packet_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_accepted;
  logic [15:0] out_agreed_block_size;
  logic [15:0] out_agreed_window_size;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  verdict_book book = new();
  logic [7:0]  pkt[$];
  bit          tx_quiet;
  bit          rx_quiet;
  bit          hold_go;
  int          sent_bytes;

  oack_option_parser dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("oack_option_parser: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver side: random stalls, calm stretches, and one long hold-off
  initial begin
    int span;
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        for (span = 0; span < HOLD_CYCLES; span++) @(posedge clk);
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
        span = pick_gap();
        repeat (span + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_verdict(out_accepted, out_agreed_block_size, out_agreed_window_size);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_packet_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_byte(b, last);
    sent_bytes++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // wait until every verdict is in and the parser has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (book.due_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_requests(input logic [15:0] blk, input logic [15:0] win);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_REQ_BLOCK;
    cfg_wdata <= blk;
    @(posedge clk);
    cfg_index <= CFG_REQ_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.req_block = blk;
    book.req_window = win;
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endfunction

  function automatic void put_opt(string name, string value);
    put_text(name);
    pkt.push_back(8'd0);
    put_text(value);
    pkt.push_back(8'd0);
  endfunction

  function automatic void start_oack();
    pkt.delete();
    pkt.push_back(8'd0);
    pkt.push_back(OPCODE_OACK);
  endfunction

  function automatic void put_name_mixed(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 2) == 0) c = c - 8'd32;
      pkt.push_back(c);
    end
  endfunction

  function automatic void put_value(bit is_blk);
    int unsigned v;
    int unsigned lo;
    int unsigned hi;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      repeat ($urandom_range(1, 3))
        pkt.push_back($urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 13)));
    else if (r < 17)
      pkt.push_back($urandom_range(0, 1) ? 8'd8 : 8'd14);
    r = $urandom_range(0, 99);
    if (r < 6) pkt.push_back("+");
    else if (r < 12) pkt.push_back("-");
    r = $urandom_range(0, 99);
    if (r < 3) begin
      // no digits at all
    end else if (r < 8) begin
      repeat ($urandom_range(6, 9)) pkt.push_back(8'("0" + $urandom_range(0, 9)));
    end else begin
      if (is_blk) begin
        lo = MIN_BLOCK;
        hi = (book.req_block < MAX_BLOCK) ? book.req_block : MAX_BLOCK;
      end else begin
        lo = 1;
        hi = (book.req_window == 0) ? 65535 : book.req_window;
      end
      if (r < 25) begin
        case ($urandom_range(0, 2))
          0: v = is_blk ? $urandom_range(0, 7) : 0;
          1: v = hi + $urandom_range(1, 50);
          default: v = $urandom_range(65465, 131070);
        endcase
      end else if (r < 40) begin
        v = $urandom_range(0, 1) ? lo : hi;
      end else begin
        v = $urandom_range(lo, hi);
      end
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) pkt.push_back("0");
      put_text($sformatf("%0d", v));
    end
    if ($urandom_range(0, 99) < 4) pkt.push_back(8'($urandom_range(1, 255)));
    pkt.push_back(8'd0);
  endfunction

  // mostly well-formed packets with random content, some noise and broken ones
  function automatic void build_packet();
    int r;
    int nopt;
    int kind;
    pkt.delete();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
      return;
    end
    if (r < 9) begin
      pkt.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'd0);
      pkt.push_back(8'($urandom));
    end else begin
      pkt.push_back(8'd0);
      pkt.push_back(OPCODE_OACK);
    end
    r = $urandom_range(0, 99);
    nopt = (r < 5) ? 0 : (r < 50) ? 1 : (r < 92) ? 2 : 3;
    for (int k = 0; k < nopt; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        put_name_mixed("blksize");
        pkt.push_back(8'd0);
        put_value(1'b1);
      end else if (kind < 90) begin
        put_name_mixed("windowsize");
        pkt.push_back(8'd0);
        put_value(1'b0);
      end else begin
        case ($urandom_range(0, 4))
          0: begin
          end
          1: put_name_mixed("blksiz");
          2: put_name_mixed("windowsizes");
          3: repeat ($urandom_range(11, 20)) pkt.push_back(8'($urandom_range(1, 255)));
          default: put_name_mixed("windowsiz");
        endcase
        pkt.push_back(8'd0);
        put_value(1'($urandom_range(0, 1)));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 6 && pkt.size() > 2) repeat ($urandom_range(1, 2)) void'(pkt.pop_back());
    else if (r < 9) pkt.push_back(8'($urandom));
  endfunction

  task automatic run_phase(input logic [15:0] blk, input logic [15:0] win,
                           input bit quiet, input bit hold, input int nbytes);
    int stop;
    drain();
    set_requests(blk, win);
    tx_quiet = quiet;
    rx_quiet = quiet;
    hold_go = hold;
    stop = sent_bytes + nbytes;
    while (sent_bytes < stop) begin
      build_packet();
      send_packet();
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    in_packet_byte <= '0;
    in_last_byte <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_REQ_BLOCK;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset requests: nothing asked for, so any option is refused
    start_oack(); put_opt("blksize", "1024"); send_packet();
    start_oack(); put_opt("windowsize", "4"); send_packet();
    start_oack(); send_packet();
    pkt.delete(); pkt.push_back(8'd0); send_packet();
    drain();

    set_requests(MAX_BLOCK, 16'hFFFF);
    start_oack(); put_opt("BLKSIZE", "65464"); send_packet();
    start_oack(); put_opt("WindowSize", " \t+65535"); send_packet();
    start_oack(); put_opt("blksize", "8"); put_opt("windowsize", "1"); send_packet();
    start_oack(); put_opt("blksize", "7"); send_packet();
    start_oack(); put_opt("blksize", "65465"); send_packet();
    start_oack(); put_opt("windowsize", "0"); send_packet();
    start_oack(); put_opt("blksize", "512"); put_opt("blksize", "512"); send_packet();
    start_oack(); put_opt("blksize", "-5"); send_packet();
    start_oack(); put_opt("windowsize", "-"); send_packet();
    start_oack(); put_opt("windowsize", "+"); send_packet();
    start_oack(); put_opt("blksize", "99999999"); send_packet();
    start_oack(); put_opt("windowsizeblksize", "1"); send_packet();
    start_oack(); put_opt("", "8"); send_packet();
    start_oack(); put_opt("blksize", ""); send_packet();
    start_oack(); put_opt("blksize", "12a"); send_packet();
    // truncated packets: inside a name, inside a value, right after a name
    start_oack(); put_text("blksi"); send_packet();
    start_oack(); put_text("blksize"); pkt.push_back(8'd0); put_text("64"); send_packet();
    start_oack(); put_text("windowsize"); pkt.push_back(8'd0); send_packet();
    // wrong opcode, the rest of the packet is skipped
    pkt.delete(); pkt.push_back(8'hFF); pkt.push_back(OPCODE_OACK);
    put_opt("blksize", "64"); send_packet();

    run_phase(MAX_BLOCK, 16'hFFFF, 1'b0, 1'b0, 230);
    run_phase(MIN_BLOCK, 16'd1, 1'b0, 1'b0, 140);
    run_phase(DEFAULT_BLOCK, 16'd0, 1'b0, 1'b0, 100);
    run_phase(16'($urandom_range(MIN_BLOCK, MAX_BLOCK)), 16'($urandom_range(1, 65535)),
              1'b1, 1'b0, 230);
    run_phase(16'($urandom_range(MIN_BLOCK, MAX_BLOCK)), 16'd0, 1'b0, 1'b1, 240);
    run_phase(16'd1024, 16'd16, 1'b0, 1'b0, 210);
    drain();

    if (book.errors == 0 && book.due_verdicts.size() == 0)
      $display("oack_option_parser: match");
    else
      $display("oack_option_parser: mismatch");
    $finish;
  end
endmodule
